/* src/mbd_pkg.sv */
`timescale 1ns / 1ps

package mbd_pkg;

    localparam int BYTE_W    = 8;
    localparam int MODE_W    = 2;
    localparam int MAX_OUT   = 3;
    localparam int CNT_W     = 2;
    localparam int SEXTET_W  = 6;
    localparam int SLOT_W    = 7;
    localparam int STORE_W   = 21;

    localparam logic [BYTE_W-1:0] CH_EQ         = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_SPACE      = 8'h20;

    typedef enum logic [MODE_W-1:0] {
        MODE_PASS = 2'd0,
        MODE_QP   = 2'd1,
        MODE_Q    = 2'd2,
        MODE_B64  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ESC_IDLE  = 3'b001,
        ESC_EQ    = 3'b010,
        ESC_DIGIT = 3'b100
    } esc_t;

    typedef struct packed {
        logic [MAX_OUT-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]               count;
    } result_t;

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] hex_val(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        v = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    // bit 6 valid, bits 5:0 symbol value
    function automatic logic [SLOT_W-1:0] b64_slot(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        logic              ok;
        v  = 8'h00;
        ok = 1'b1;
        if (c >= 8'h41 && c <= 8'h5A) begin
            v = c - 8'h41;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            v = c - 8'h47;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            v = c + 8'h04;
        end else if (c == 8'h2B) begin
            v = 8'd62;
        end else if (c == 8'h2F) begin
            v = 8'd63;
        end else begin
            ok = 1'b0;
        end
        return {ok, v[SEXTET_W-1:0]};
    endfunction

endpackage

/* src/mbd_decode.sv */
`timescale 1ns / 1ps

module mbd_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mbd_pkg::MODE_W-1:0]    cfg_wr_data,
    input  logic                          in_fire,
    input  logic [mbd_pkg::BYTE_W-1:0]    text_byte,
    input  logic                          final_byte,
    output mbd_pkg::result_t              res
);
    import mbd_pkg::*;

    mode_t               mode_reg;
    esc_t                phase_reg, phase_next;
    logic [BYTE_W-1:0]   held_reg, held_next;
    logic [CNT_W-1:0]    gc_reg, gc_next;
    logic [STORE_W-1:0]  store_reg, store_next;

    logic [CNT_W-1:0]    cnt;
    logic                do_plain;
    logic [SLOT_W-1:0]   s;
    logic [SLOT_W-1:0]   xs, ys, zs;
    logic [23:0]         b64_sum;

    assign s  = b64_slot(text_byte);
    assign xs = store_reg[SLOT_W-1:0];
    assign ys = store_reg[2*SLOT_W-1:SLOT_W];
    assign zs = store_reg[3*SLOT_W-1:2*SLOT_W];

    // invalid third symbol counts as minus one in the sum
    assign b64_sum = {xs[SEXTET_W-1:0], ys[SEXTET_W-1:0], 12'h000} + 24'hFFFFC0
                   + {18'h00000, s[SEXTET_W-1:0]};

    always_comb begin
        phase_next = phase_reg;
        held_next  = held_reg;
        gc_next    = gc_reg;
        store_next = store_reg;
        res        = '0;
        cnt        = '0;
        do_plain   = 1'b0;

        unique case (mode_reg) inside
            MODE_PASS: begin
                res.bytes[cnt] = text_byte;
                cnt = cnt + 2'd1;
            end
            MODE_B64: begin
                if (gc_reg != 2'd3) begin
                    case (gc_reg)
                        2'd0:    store_next[SLOT_W-1:0]          = s;
                        2'd1:    store_next[2*SLOT_W-1:SLOT_W]   = s;
                        default: store_next[3*SLOT_W-1:2*SLOT_W] = s;
                    endcase
                    gc_next = gc_reg + 2'd1;
                end else begin
                    gc_next    = '0;
                    store_next = '0;
                    if (xs[SLOT_W-1] && ys[SLOT_W-1]) begin
                        if (!zs[SLOT_W-1] && !s[SLOT_W-1]) begin
                            res.bytes[0] = {xs[5:0], ys[5:4]};
                            cnt = 2'd1;
                        end else if (!s[SLOT_W-1]) begin
                            res.bytes[0] = {xs[5:0], ys[5:4]};
                            res.bytes[1] = {ys[3:0], zs[5:2]};
                            cnt = 2'd2;
                        end else if (zs[SLOT_W-1]) begin
                            res.bytes[0] = {xs[5:0], ys[5:4]};
                            res.bytes[1] = {ys[3:0], zs[5:2]};
                            res.bytes[2] = {zs[1:0], s[5:0]};
                            cnt = 2'd3;
                        end else begin
                            res.bytes[0] = b64_sum[23:16];
                            res.bytes[1] = b64_sum[15:8];
                            res.bytes[2] = b64_sum[7:0];
                            cnt = 2'd3;
                        end
                    end
                end
            end
            MODE_QP, MODE_Q: begin
                unique case (phase_reg)
                    ESC_EQ: begin
                        if (is_hex(text_byte)) begin
                            held_next  = text_byte;
                            phase_next = ESC_DIGIT;
                        end else begin
                            phase_next = ESC_IDLE;
                            do_plain   = 1'b1;
                        end
                    end
                    ESC_DIGIT: begin
                        phase_next = ESC_IDLE;
                        held_next  = '0;
                        if (is_hex(text_byte)) begin
                            res.bytes[cnt] = {hex_val(held_reg), hex_val(text_byte)};
                            cnt = cnt + 2'd1;
                        end else begin
                            res.bytes[cnt] = held_reg;
                            cnt = cnt + 2'd1;
                            do_plain = 1'b1;
                        end
                    end
                    default: begin
                        phase_next = ESC_IDLE;
                        do_plain   = 1'b1;
                    end
                endcase
                if (do_plain) begin
                    if (text_byte == CH_EQ) begin
                        phase_next = ESC_EQ;
                    end else if (mode_reg == MODE_Q && text_byte == CH_UNDERSCORE) begin
                        res.bytes[cnt] = CH_SPACE;
                        cnt = cnt + 2'd1;
                    end else begin
                        res.bytes[cnt] = text_byte;
                        cnt = cnt + 2'd1;
                    end
                end
            end
            default: begin
                cnt = '0;
            end
        endcase

        if (final_byte) begin
            if ((mode_reg == MODE_QP || mode_reg == MODE_Q) && phase_next == ESC_DIGIT) begin
                res.bytes[cnt] = held_next;
                cnt = cnt + 2'd1;
            end
            phase_next = ESC_IDLE;
            held_next  = '0;
            gc_next    = '0;
            store_next = '0;
        end
        res.count = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PASS;
            phase_reg <= ESC_IDLE;
            held_reg  <= '0;
            gc_reg    <= '0;
            store_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= mode_t'(cfg_wr_data);
            end
            if (in_fire) begin
                phase_reg <= phase_next;
                held_reg  <= held_next;
                gc_reg    <= gc_next;
                store_reg <= store_next;
            end
        end
    end

endmodule

/* src/mbd_outbuf.sv */
`timescale 1ns / 1ps

module mbd_outbuf (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_fire,
    input  mbd_pkg::result_t              res,
    output logic                          in_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mbd_pkg::BYTE_W-1:0]    m_decoded_byte,
    output logic                          m_last_of_run
);
    import mbd_pkg::*;

    logic [MAX_OUT-1:0][BYTE_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           out_fire;

    assign m_valid        = (cnt_reg != '0);
    assign m_last_of_run  = (cnt_reg == 2'd1);
    assign m_decoded_byte = data_reg[0];
    assign out_fire       = m_valid && m_ready;
    // buffer is free once its last byte leaves this cycle
    assign in_ready       = (cnt_reg == '0) || (cnt_reg == 2'd1 && m_ready);

    always_comb begin
        data_next = data_reg;
        cnt_next  = cnt_reg;
        if (in_fire) begin
            data_next = res.bytes;
            cnt_next  = res.count;
        end else if (out_fire) begin
            data_next = {8'h00, data_reg[2], data_reg[1]};
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

/* src/mime_body_decoder.sv */
`timescale 1ns / 1ps

// channel   direction  handshake         payload
// s_        in         s_valid/s_ready   s_text_byte, s_final_byte
// m_        out        m_valid/m_ready   m_decoded_byte, m_last_of_run
// cfg_      in         cfg_wr_en         cfg_wr_data (mode)
//
// one input transfer per cycle while each byte yields at most one output byte
// and m_ready is high; a byte that completes a base64 group yields up to three,
// a broken escape two, and the output buffer drains one per cycle while m_ready
// is high, holding s_ready low until its last byte leaves.
// results are registered and appear in the cycle after the input transfer.
// synchronous active-low reset clears mode, escape and group state.

module mime_body_decoder (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mbd_pkg::MODE_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mbd_pkg::BYTE_W-1:0]    s_text_byte,
    input  logic                          s_final_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [mbd_pkg::BYTE_W-1:0]    m_decoded_byte,
    output logic                          m_last_of_run
);
    import mbd_pkg::*;

    result_t res;
    logic    in_fire;

    assign in_fire = s_valid && s_ready;

    mbd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_fire     (in_fire),
        .text_byte   (s_text_byte),
        .final_byte  (s_final_byte),
        .res         (res)
    );

    mbd_outbuf u_outbuf (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_fire        (in_fire),
        .res            (res),
        .in_ready       (s_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_decoded_byte (m_decoded_byte),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

/* tb/mime_body_decoder_tb.sv */
`timescale 1ns / 1ps

module mime_body_decoder_tb;
    import mbd_pkg::*;

    localparam int    LIMIT_CYCLES = 300000;
    localparam int    SETTLE       = 4;
    localparam int    PHASE_ITEMS  = 24;
    localparam string B64_SYMBOLS  =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam string HEX_CHARS    = "0123456789ABCDEFabcdef";

    typedef enum logic [1:0] {
        NO_ESCAPE  = 2'd0,
        SAW_EQUALS = 2'd1,
        SAW_DIGIT  = 2'd2
    } escape_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    typedef struct packed {
        logic [7:0] text;
        logic       fin;
    } text_item_t;

    class decoded_byte_board_t;
        mode_t       mode;
        escape_t     escape;
        logic [7:0]  held_digit;
        logic [1:0]  group_fill;
        logic [20:0] slots;
        logic [7:0]  run_bytes[$];
        out_byte_t   expected_bytes[$];
        int          errors;

        function new();
            mode       = MODE_PASS;
            escape     = NO_ESCAPE;
            held_digit = '0;
            group_fill = '0;
            slots      = '0;
            errors     = 0;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // {valid, nibble}
        function logic [4:0] hex_of(logic [7:0] c);
            logic [7:0] folded;
            folded = c | 8'h20;
            if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
            if (folded >= "a" && folded <= "f") return {1'b1, c[3:0] + 4'd9};
            return 5'd0;
        endfunction

        // {valid, sextet}
        function logic [6:0] slot_of(logic [7:0] c);
            for (int k = 0; k < 64; k++) begin
                if (B64_SYMBOLS[k] == c) return {1'b1, 6'(k)};
            end
            return 7'd0;
        endfunction

        function void emit(logic [7:0] b);
            if (run_bytes.size() < MAX_OUT) run_bytes.push_back(b);
        endfunction

        function void qp_plain(logic [7:0] c);
            if (c == CH_EQ) begin
                escape = SAW_EQUALS;
            end else if (mode == MODE_Q && c == CH_UNDERSCORE) begin
                emit(CH_SPACE);
            end else begin
                emit(c);
            end
        endfunction

        function void qp_step(logic [7:0] c);
            logic [4:0] hi;
            logic [4:0] lo;
            lo = hex_of(c);
            case (escape)
                SAW_EQUALS: begin
                    if (lo[4]) begin
                        held_digit = c;
                        escape     = SAW_DIGIT;
                    end else begin
                        escape = NO_ESCAPE;
                        qp_plain(c);
                    end
                end
                SAW_DIGIT: begin
                    escape = NO_ESCAPE;
                    if (lo[4]) begin
                        hi = hex_of(held_digit);
                        emit({hi[3:0], lo[3:0]});
                    end else begin
                        emit(held_digit);
                        qp_plain(c);
                    end
                    held_digit = '0;
                end
                default: begin
                    escape = NO_ESCAPE;
                    qp_plain(c);
                end
            endcase
        endfunction

        function void b64_step(logic [7:0] c);
            logic [6:0]  s;
            logic [6:0]  xs;
            logic [6:0]  ys;
            logic [6:0]  zs;
            logic [23:0] n;
            s = slot_of(c);
            if (group_fill < 2'd3) begin
                slots      = slots | ({14'd0, s} << (7 * group_fill));
                group_fill = group_fill + 2'd1;
                return;
            end
            xs         = slots[6:0];
            ys         = slots[13:7];
            zs         = slots[20:14];
            group_fill = '0;
            slots      = '0;
            if (!xs[6] || !ys[6]) return;
            n = {xs[5:0], ys[5:0], 12'd0};
            if (!zs[6] && !s[6]) begin
                emit(n[23:16]);
            end else if (!s[6]) begin
                n[11:6] = zs[5:0];
                emit(n[23:16]);
                emit(n[15:8]);
            end else begin
                // missing third symbol weighs in as minus one
                if (zs[6]) begin
                    n[11:6] = zs[5:0];
                end else begin
                    n = n - 24'd64;
                end
                n = n + {18'd0, s[5:0]};
                emit(n[23:16]);
                emit(n[15:8]);
                emit(n[7:0]);
            end
        endfunction

        function void accept_text(logic [7:0] c, logic fin);
            run_bytes.delete();
            case (mode)
                MODE_PASS: emit(c);
                MODE_B64:  b64_step(c);
                default:   qp_step(c);
            endcase
            if (fin) begin
                if ((mode == MODE_QP || mode == MODE_Q) && escape == SAW_DIGIT) begin
                    emit(held_digit);
                end
                escape     = NO_ESCAPE;
                held_digit = '0;
                group_fill = '0;
                slots      = '0;
            end
            foreach (run_bytes[i]) begin
                expected_bytes.push_back({run_bytes[i], i == run_bytes.size() - 1});
            end
        endfunction

        function void check_byte(logic [7:0] data, logic last);
            out_byte_t want;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected output byte %02h last_of_run %0b",
                         $time, data, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data) begin
                errors++;
                $display("%0t: decoded_byte expected %02h actual %02h",
                         $time, want.data, data);
            end
            if (last !== want.last) begin
                errors++;
                $display("%0t: last_of_run expected %0b actual %0b",
                         $time, want.last, last);
            end
        endfunction
    endclass

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 cfg_wr_en      = 1'b0;
    logic [MODE_W-1:0]    cfg_wr_data    = '0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_text_byte    = 8'h01;
    logic                 s_final_byte   = 1'b0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [BYTE_W-1:0]    m_decoded_byte;
    logic                 m_last_of_run;

    decoded_byte_board_t  board;
    text_item_t           plan[$];
    bit                   steady         = 1'b0;
    int unsigned          cycle_count    = 0;

    mime_body_decoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_text_byte    (s_text_byte),
        .s_final_byte   (s_final_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_decoded_byte (m_decoded_byte),
        .m_last_of_run  (m_last_of_run)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_byte(m_decoded_byte, m_last_of_run);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // result side stalls
    initial begin
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (steady) begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    function automatic void add_byte(logic [7:0] b, bit fin);
        text_item_t it;
        it.text = b;
        it.fin  = fin;
        plan.push_back(it);
    endfunction

    function automatic void add_text(string s, bit fin_last);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i], fin_last && i == s.len() - 1);
        end
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] c;
        logic [4:0] h;
        do begin
            c = any_byte();
            h = board.hex_of(c);
        end while (h[4]);
        return c;
    endfunction

    function automatic void fill_pass(int count);
        while (plan.size() < count) begin
            add_byte(any_byte(), $urandom_range(0, 15) == 0);
        end
    endfunction

    function automatic void fill_qp(int count);
        int r;
        while (plan.size() < count) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_byte(8'($urandom_range(32, 126)), 1'b0);
            end else if (r < 65) begin
                add_byte(CH_EQ, 1'b0);
                add_byte(HEX_CHARS[$urandom_range(0, 21)], 1'b0);
                add_byte(HEX_CHARS[$urandom_range(0, 21)], 1'b0);
            end else if (r < 75) begin
                add_byte(CH_UNDERSCORE, 1'b0);
            end else if (r < 82) begin
                add_byte(CH_EQ, 1'b0);
                add_byte(non_hex_byte(), 1'b0);
            end else if (r < 89) begin
                add_byte(CH_EQ, 1'b0);
                add_byte(HEX_CHARS[$urandom_range(0, 21)], 1'b0);
                add_byte(non_hex_byte(), 1'b0);
            end else begin
                add_byte(any_byte(), 1'b0);
            end
            if ($urandom_range(0, 11) == 0) plan[plan.size() - 1].fin = 1'b1;
        end
    endfunction

    function automatic void fill_b64(int count);
        int r;
        while (plan.size() < count) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                add_byte(any_byte(), 1'b0);
            end else begin
                add_byte(B64_SYMBOLS[$urandom_range(0, 63)], 1'b0);
            end
            if (r >= 4 && r < 8) begin
                add_byte(CH_EQ, 1'b0);
            end else begin
                add_byte(B64_SYMBOLS[$urandom_range(0, 63)], 1'b0);
            end
            if ($urandom_range(0, 9) == 0) begin
                // partial group cut off by the end of text
                plan[plan.size() - 1].fin = 1'b1;
                continue;
            end
            if ((r >= 70 && r < 80) || (r >= 90 && r < 96)) begin
                add_byte(CH_EQ, 1'b0);
            end else begin
                add_byte(B64_SYMBOLS[$urandom_range(0, 63)], 1'b0);
            end
            if (r >= 70 && r < 90) begin
                add_byte(CH_EQ, 1'b0);
            end else if (r >= 96) begin
                add_byte(any_byte(), 1'b0);
            end else begin
                add_byte(B64_SYMBOLS[$urandom_range(0, 63)], 1'b0);
            end
            if ($urandom_range(0, 11) == 0) plan[plan.size() - 1].fin = 1'b1;
        end
    endfunction

    task automatic send_text(text_item_t it, bit hold);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (hold || gap > 0) s_valid <= 1'b0;
        if (hold) begin
            do @(posedge aclk); while (board.pending() != 0);
        end
        repeat (gap) @(posedge aclk);
        s_valid      <= 1'b1;
        s_text_byte  <= it.text;
        s_final_byte <= it.fin;
        do @(posedge aclk); while (!s_ready);
        board.accept_text(it.text, it.fin);
    endtask

    task automatic run_plan();
        for (int i = 0; i < plan.size(); i++) begin
            send_text(plan[i], i == 10 || $urandom_range(0, 59) == 0);
        end
        s_valid <= 1'b0;
        plan.delete();
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_mode(mode_t m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        board.mode = m;
    endtask

    task automatic run_phase(mode_t m);
        wait_drained();
        set_mode(m);
        run_plan();
    endtask

    initial begin
        mode_t m;
        board = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        add_byte(8'h01, 1'b0);
        add_byte(8'hFF, 1'b1);
        run_phase(MODE_PASS);

        // good escape, digit then junk, lone escape, digit held at end of text
        add_text("=Ff=5z=g", 1'b0);
        add_text("=a", 1'b1);
        run_phase(MODE_QP);

        // underscore to space, dangling escape at end of text
        add_text("_=", 1'b1);
        run_phase(MODE_Q);

        // invalid third symbol with valid fourth, double padding, partial group
        add_text("TW=uTW==", 1'b0);
        add_text("A", 1'b1);
        run_phase(MODE_B64);

        for (int p = 0; p < 10; p++) begin
            case (p)
                0:       m = MODE_B64;
                1:       m = MODE_QP;
                2:       m = MODE_PASS;
                3:       m = MODE_Q;
                default: m = mode_t'($urandom_range(0, 3));
            endcase
            case (m)
                MODE_PASS: fill_pass(PHASE_ITEMS);
                MODE_B64:  fill_b64(PHASE_ITEMS);
                default:   fill_qp(PHASE_ITEMS);
            endcase
            wait_drained();
            steady = (p == 2 || p == 7);
            run_phase(m);
        end
        steady = 1'b0;

        wait_drained();
        repeat (8) @(posedge aclk);
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
